FILE: rtl/msdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msdr_pkg
// Shared types and constants of the median send-on-delta reporter.
// ----------------------------------------------------------------------------
package msdr_pkg;

  localparam int WINDOW  = 5;
  localparam int CNT_W   = $clog2(WINDOW);
  localparam int MID     = WINDOW / 2;

  localparam int DIST_W  = 16;
  localparam int TIME_W  = 32;
  localparam int CHG_W   = 10;
  localparam int SLEEP_W = 17;
  localparam int LEVEL_W = 18;
  localparam int DELTA_W = 16;

  localparam int IN_W    = 64;
  localparam int OUT_W   = 40;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = -18'sd300;

  // register word indexes
  localparam logic [2:0] REG_DELTA    = 3'd0;
  localparam logic [2:0] REG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_LOW_LVL  = 3'd2;
  localparam logic [2:0] REG_CRIT_LVL = 3'd3;
  localparam logic [2:0] REG_NORM_S   = 3'd4;
  localparam logic [2:0] REG_LOW_S    = 3'd5;
  localparam logic [2:0] REG_CRIT_S   = 3'd6;

  typedef struct packed {
    logic [DELTA_W-1:0] report_delta;
    logic [TIME_W-1:0]  report_period_ms;
    logic [CHG_W-1:0]   low_charge_level;
    logic [CHG_W-1:0]   critical_charge_level;
    logic [SLEEP_W-1:0] normal_sleep_s;
    logic [SLEEP_W-1:0] low_sleep_s;
    logic [SLEEP_W-1:0] critical_sleep_s;
  } cfg_t;

  // what one sorting cell shows its right neighbor
  typedef struct packed {
    logic              keep;
    logic              vld;
    logic [DIST_W-1:0] val;
  } link_t;

endpackage
`default_nettype wire

FILE: rtl/median_send_on_delta_reporter_unit.sv
`default_nettype none
// a window's last sample passes the evaluation stage and report output
// registers to reach m_tdata; throughput: one item per cycle if the output is
// not stalled; a sorting-cell chain inserts each sample on load and the
// decision stage keeps pace through its output register; only the last sample
// of each window of five gives a result item; reset: synchronous, clears window
// fill, last level to -300, report time to 0, registers to their defaults
// ----------------------------------------------------------------------------
// median_send_on_delta_reporter_unit
// Median-of-window filter with send-on-delta reporting and sleep selection.
// ----------------------------------------------------------------------------
module median_send_on_delta_reporter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // distance[15:0], now_ms[47:16], charge[57:48], zeros above
  input  wire logic [msdr_pkg::IN_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // median_level[15:0], publish[16], sleep_request[17], sleep_seconds[34:18],
  // zeros above
  output logic [msdr_pkg::OUT_W-1:0]         m_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msdr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [msdr_pkg::DATA_W-1:0]   pwdata,
  output logic [msdr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  msdr_pkg::cfg_t                 cfg;
  logic [2:0]                     reg_idx;
  logic                           wr_en;

  logic [msdr_pkg::DIST_W-1:0]    distance;
  logic [msdr_pkg::TIME_W-1:0]    now_in;
  logic [msdr_pkg::CHG_W-1:0]     charge_in;
  logic                           load;
  logic                           start;
  logic                           last;
  logic [msdr_pkg::CNT_W-1:0]     count;

  msdr_pkg::link_t                links [msdr_pkg::WINDOW+1];
  logic [msdr_pkg::DIST_W-1:0]    nxt   [msdr_pkg::WINDOW];

  logic                           ev_valid;
  logic                           ev_ready;
  logic [msdr_pkg::DIST_W-1:0]    ev_median;
  logic [msdr_pkg::TIME_W-1:0]    ev_now;
  logic [msdr_pkg::CHG_W-1:0]     ev_charge;

  logic [msdr_pkg::DIST_W-1:0]    median_level;
  logic                           publish;
  logic                           sleep_request;
  logic [msdr_pkg::SLEEP_W-1:0]   sleep_seconds;

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.report_delta          <= 16'd100;
      cfg.report_period_ms      <= 32'd900000;
      cfg.low_charge_level      <= 10'd200;
      cfg.critical_charge_level <= 10'd50;
      cfg.normal_sleep_s        <= 17'd900;
      cfg.low_sleep_s           <= 17'd3600;
      cfg.critical_sleep_s      <= 17'd86400;
    end else if (wr_en) begin
      unique case (reg_idx)
        msdr_pkg::REG_DELTA:    cfg.report_delta          <= pwdata[15:0];
        msdr_pkg::REG_PERIOD:   cfg.report_period_ms      <= pwdata;
        msdr_pkg::REG_LOW_LVL:  cfg.low_charge_level      <= pwdata[9:0];
        msdr_pkg::REG_CRIT_LVL: cfg.critical_charge_level <= pwdata[9:0];
        msdr_pkg::REG_NORM_S:   cfg.normal_sleep_s        <= pwdata[16:0];
        msdr_pkg::REG_LOW_S:    cfg.low_sleep_s           <= pwdata[16:0];
        msdr_pkg::REG_CRIT_S:   cfg.critical_sleep_s      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      msdr_pkg::REG_DELTA:    prdata = 32'(cfg.report_delta);
      msdr_pkg::REG_PERIOD:   prdata = cfg.report_period_ms;
      msdr_pkg::REG_LOW_LVL:  prdata = 32'(cfg.low_charge_level);
      msdr_pkg::REG_CRIT_LVL: prdata = 32'(cfg.critical_charge_level);
      msdr_pkg::REG_NORM_S:   prdata = 32'(cfg.normal_sleep_s);
      msdr_pkg::REG_LOW_S:    prdata = 32'(cfg.low_sleep_s);
      msdr_pkg::REG_CRIT_S:   prdata = 32'(cfg.critical_sleep_s);
      default:                prdata = '0;
    endcase
  end

  // ---------------- input side and window fill
  assign distance  = s_tdata[15:0];
  assign now_in    = s_tdata[47:16];
  assign charge_in = s_tdata[57:48];

  assign s_tready = !ev_valid || ev_ready;
  assign load     = s_tvalid && s_tready;
  assign start    = (count == '0);
  assign last     = (count == msdr_pkg::CNT_W'(msdr_pkg::WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= last ? '0 : count + 1'b1;
    end
  end

  // ---------------- sorting chain, lowest value in cell 0
  assign links[0] = '{keep: 1'b1, vld: 1'b0, val: '0};

  for (genvar i = 0; i < msdr_pkg::WINDOW; i++) begin : g_cell
    msdr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (load),
      .start    (start),
      .x        (distance),
      .left     (links[i]),
      .link     (links[i+1]),
      .val_next (nxt[i])
    );
  end

  // ---------------- evaluation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (load) begin
      ev_valid <= last;
    end else if (ev_ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && last) begin
      ev_median <= nxt[msdr_pkg::MID];
      ev_now    <= now_in;
      ev_charge <= charge_in;
    end
  end

  msdr_report u_report (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ev_valid      (ev_valid),
    .ev_ready      (ev_ready),
    .median        (ev_median),
    .now_ms        (ev_now),
    .charge        (ev_charge),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .median_level  (median_level),
    .publish       (publish),
    .sleep_request (sleep_request),
    .sleep_seconds (sleep_seconds)
  );

  assign m_tdata = {5'b00000, sleep_seconds, sleep_request, publish, median_level};

endmodule
`default_nettype wire

FILE: rtl/msdr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msdr_cell
// One slot of the insertion-sort chain; holds one sample of the window.
// ----------------------------------------------------------------------------
module msdr_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic                        start,
  input  wire logic [msdr_pkg::DIST_W-1:0] x,
  input  wire msdr_pkg::link_t             left,
  output msdr_pkg::link_t                  link,
  output logic [msdr_pkg::DIST_W-1:0]      val_next
);

  logic [msdr_pkg::DIST_W-1:0] val;
  logic                        vld;
  logic                        vld_next;
  logic                        eff_vld;

  // a new window makes every held sample stale
  assign eff_vld = vld && !start;

  assign link.vld  = eff_vld;
  assign link.val  = val;
  assign link.keep = eff_vld && (val <= x);

  always_comb begin
    if (link.keep) begin
      val_next = val;
      vld_next = 1'b1;
    end else if (left.keep) begin
      val_next = x;
      vld_next = 1'b1;
    end else begin
      val_next = left.val;
      vld_next = left.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/msdr_report.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msdr_report
// Send-on-delta and period decision, sleep choice and output register.
// ----------------------------------------------------------------------------
module msdr_report (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire msdr_pkg::cfg_t               cfg,
  input  wire logic                         ev_valid,
  output logic                              ev_ready,
  input  wire logic [msdr_pkg::DIST_W-1:0]  median,
  input  wire logic [msdr_pkg::TIME_W-1:0]  now_ms,
  input  wire logic [msdr_pkg::CHG_W-1:0]   charge,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [msdr_pkg::DIST_W-1:0]       median_level,
  output logic                              publish,
  output logic                              sleep_request,
  output logic [msdr_pkg::SLEEP_W-1:0]      sleep_seconds
);

  logic signed [msdr_pkg::LEVEL_W-1:0] last_level;
  logic [msdr_pkg::TIME_W-1:0]         last_time;
  logic signed [msdr_pkg::LEVEL_W-1:0] diff;
  logic [msdr_pkg::LEVEL_W-2:0]        mag;
  logic [msdr_pkg::TIME_W-1:0]         elapsed;
  logic                                big;
  logic                                been;
  logic [msdr_pkg::SLEEP_W-1:0]        sleep_sel;
  logic                                take;

  assign ev_ready = !out_valid || out_ready;
  assign take     = ev_valid && ev_ready;

  // range of diff stays within 18 bits signed, so magnitude fits in 17
  assign diff = last_level - $signed({2'b00, median});
  assign mag  = diff[msdr_pkg::LEVEL_W-1] ? (msdr_pkg::LEVEL_W-1)'(-diff) : diff[16:0];
  assign big  = mag > {1'b0, cfg.report_delta};

  assign elapsed = now_ms - last_time;
  assign been    = elapsed >= cfg.report_period_ms;

  always_comb begin
    sleep_sel = cfg.normal_sleep_s;
    if (charge < cfg.critical_charge_level) begin
      sleep_sel = cfg.critical_sleep_s;
    end else if (charge < cfg.low_charge_level) begin
      sleep_sel = cfg.low_sleep_s;
    end
    if (!been) begin
      sleep_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_level <= msdr_pkg::LEVEL_RESET;
      last_time  <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (been || big) begin
          last_time <= now_ms;
        end
        if (big) begin
          last_level <= $signed({2'b00, median});
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      median_level  <= median;
      publish       <= been || big;
      sleep_request <= been;
      sleep_seconds <= sleep_sel;
    end
  end

endmodule
`default_nettype wire

FILE: bench/median_send_on_delta_reporter_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_send_on_delta_reporter_unit_test
// Drives windows of distance samples through the stream port and checks each
// result against a local median/report predictor. Registers are rewritten
// between phases; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module median_send_on_delta_reporter_unit_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic [msdr_pkg::SLEEP_W-1:0] sleep_seconds;
    logic                         sleep_request;
    logic                         publish;
    logic [msdr_pkg::DIST_W-1:0]  median_level;
  } report_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // distance[15:0], now_ms[47:16], charge[57:48], zeros above
  logic [msdr_pkg::IN_W-1:0]     s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // median_level[15:0], publish[16], sleep_request[17], sleep_seconds[34:18],
  // zeros above
  logic [msdr_pkg::OUT_W-1:0]    m_tdata;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [msdr_pkg::ADDR_W-1:0]   paddr    = '0;
  logic [msdr_pkg::DATA_W-1:0]   pwdata   = '0;
  logic [msdr_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  median_send_on_delta_reporter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  msdr_pkg::cfg_t                cfg;
  logic [msdr_pkg::DIST_W-1:0]   window_store [msdr_pkg::WINDOW];
  int                            fill_count;
  int                            reported_level;
  logic [msdr_pkg::TIME_W-1:0]   report_time;
  report_t                       expected_reports [$];

  int                            mismatch_count;
  int                            cycle_count;
  logic [9:0]                    stall_phase = '0;
  int                            burst_left;
  int                            max_gap;
  int                            level_hint;
  logic [msdr_pkg::TIME_W-1:0]   clock_ms;
  report_t                       want;

  function automatic logic [msdr_pkg::IN_W-1:0] pack_item(
      logic [msdr_pkg::DIST_W-1:0] distance,
      logic [msdr_pkg::TIME_W-1:0] now_ms,
      logic [msdr_pkg::CHG_W-1:0]  charge);
    return {{(msdr_pkg::IN_W-msdr_pkg::DIST_W-msdr_pkg::TIME_W-msdr_pkg::CHG_W){1'b0}},
            charge, now_ms, distance};
  endfunction

  // store one sample; at window end work out the report it causes
  task automatic median_filter_step(input logic [msdr_pkg::IN_W-1:0] item);
    logic [msdr_pkg::DIST_W-1:0] sorted [msdr_pkg::WINDOW];
    logic [msdr_pkg::DIST_W-1:0] tmp;
    logic [msdr_pkg::TIME_W-1:0] now_ms;
    logic [msdr_pkg::CHG_W-1:0]  charge;
    logic [msdr_pkg::TIME_W-1:0] elapsed;
    int                          i;
    int                          j;
    int                          diff;
    logic                        big;
    logic                        been;
    report_t                     rep;
    now_ms = item[msdr_pkg::DIST_W +: msdr_pkg::TIME_W];
    charge = item[msdr_pkg::DIST_W+msdr_pkg::TIME_W +: msdr_pkg::CHG_W];
    window_store[fill_count] = item[msdr_pkg::DIST_W-1:0];
    fill_count++;
    if (fill_count == msdr_pkg::WINDOW) begin
      fill_count = 0;
      sorted = window_store;
      for (i = 0; i < msdr_pkg::WINDOW - 1; i++)
        for (j = 0; j < msdr_pkg::WINDOW - 1 - i; j++)
          if (sorted[j] > sorted[j+1]) begin
            tmp = sorted[j];
            sorted[j] = sorted[j+1];
            sorted[j+1] = tmp;
          end
      diff = reported_level - int'(sorted[msdr_pkg::MID]);
      if (diff < 0) diff = -diff;
      big = diff > int'(cfg.report_delta);
      elapsed = now_ms - report_time;
      been = elapsed >= cfg.report_period_ms;
      if (been || big) report_time = now_ms;
      if (big) reported_level = int'(sorted[msdr_pkg::MID]);
      rep.median_level = sorted[msdr_pkg::MID];
      rep.publish = been || big;
      rep.sleep_request = been;
      rep.sleep_seconds = '0;
      if (been) begin
        // critical test wins over the low test
        if (charge < cfg.critical_charge_level)
          rep.sleep_seconds = cfg.critical_sleep_s;
        else if (charge < cfg.low_charge_level)
          rep.sleep_seconds = cfg.low_sleep_s;
        else
          rep.sleep_seconds = cfg.normal_sleep_s;
      end
      expected_reports.push_back(rep);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: m_tdata=%h", m_tdata);
      end else begin
        want = expected_reports.pop_front();
        if (m_tdata[15:0] !== want.median_level || m_tdata[16] !== want.publish ||
            m_tdata[17] !== want.sleep_request ||
            m_tdata[34:18] !== want.sleep_seconds ||
            m_tdata[msdr_pkg::OUT_W-1:35] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: median exp %0d got %0d, publish exp %0b got %0b, ",
                      "sleep exp %0b got %0b, seconds exp %0d got %0d, pad %h"},
                     want.median_level, m_tdata[15:0], want.publish, m_tdata[16],
                     want.sleep_request, m_tdata[17], want.sleep_seconds,
                     m_tdata[34:18], m_tdata[msdr_pkg::OUT_W-1:35]);
        end
      end
    end
    if (!rst && s_tvalid && s_tready) median_filter_step(s_tdata);
  end

  // receiver: always ready, random stalls, short regular stalls, long stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (stall_phase[2:0] != 3'd0);
      default: m_tready <= stall_phase[4];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("median_send_on_delta_reporter_unit verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [msdr_pkg::IN_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // only the last sample's time and charge matter; the others get noise
  task automatic send_window(
      input logic [msdr_pkg::WINDOW-1:0][msdr_pkg::DIST_W-1:0] samples,
      input logic [msdr_pkg::TIME_W-1:0] now_ms,
      input logic [msdr_pkg::CHG_W-1:0]  charge);
    int k;
    for (k = 0; k < msdr_pkg::WINDOW; k++) begin
      if (k == msdr_pkg::WINDOW - 1)
        send_item(pack_item(samples[k], now_ms, charge));
      else
        send_item(pack_item(samples[k], $urandom,
                            msdr_pkg::CHG_W'($urandom_range(0, 1023))));
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [6:0][msdr_pkg::DATA_W-1:0] values);
    int         r;
    logic [2:0] idx;
    for (r = 0; r < 7; r++) begin
      idx = r[2:0];
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= values[idx];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        msdr_pkg::REG_DELTA:
          cfg.report_delta          = values[idx][msdr_pkg::DELTA_W-1:0];
        msdr_pkg::REG_PERIOD:
          cfg.report_period_ms      = values[idx][msdr_pkg::TIME_W-1:0];
        msdr_pkg::REG_LOW_LVL:
          cfg.low_charge_level      = values[idx][msdr_pkg::CHG_W-1:0];
        msdr_pkg::REG_CRIT_LVL:
          cfg.critical_charge_level = values[idx][msdr_pkg::CHG_W-1:0];
        msdr_pkg::REG_NORM_S:
          cfg.normal_sleep_s        = values[idx][msdr_pkg::SLEEP_W-1:0];
        msdr_pkg::REG_LOW_S:
          cfg.low_sleep_s           = values[idx][msdr_pkg::SLEEP_W-1:0];
        msdr_pkg::REG_CRIT_S:
          cfg.critical_sleep_s      = values[idx][msdr_pkg::SLEEP_W-1:0];
        default: ;
      endcase
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // a drifting level with noise scaled to the delta, sometimes pure noise
  task automatic random_window;
    logic [msdr_pkg::WINDOW-1:0][msdr_pkg::DIST_W-1:0] samples;
    logic [msdr_pkg::TIME_W-1:0]                       step_max;
    logic [msdr_pkg::CHG_W-1:0]                        charge;
    int                                                k;
    int                                                v;
    int                                                spread;
    spread = int'(cfg.report_delta) / 2 + 4;
    if (spread > 20000) spread = 20000;
    if ($urandom_range(0, 9) == 0) begin
      for (k = 0; k < msdr_pkg::WINDOW; k++) samples[k] = msdr_pkg::DIST_W'($urandom);
    end else begin
      level_hint += $urandom_range(0, 6 * spread) - 3 * spread;
      if (level_hint < 0) level_hint = 0;
      if (level_hint > 65535) level_hint = 65535;
      for (k = 0; k < msdr_pkg::WINDOW; k++) begin
        v = level_hint + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        samples[k] = v[msdr_pkg::DIST_W-1:0];
      end
    end
    step_max = (cfg.report_period_ms == '0) ? 32'd5000 : (cfg.report_period_ms >> 1);
    clock_ms += $urandom_range(0, step_max);
    if ($urandom_range(0, 15) == 0) clock_ms += $urandom;
    case ($urandom_range(0, 2))
      0: charge = msdr_pkg::CHG_W'(cfg.low_charge_level + $urandom_range(0, 2) - 1);
      1: charge = msdr_pkg::CHG_W'(cfg.critical_charge_level + $urandom_range(0, 2) - 1);
      default: charge = msdr_pkg::CHG_W'($urandom_range(0, 1023));
    endcase
    send_window(samples, clock_ms, charge);
  endtask

  task automatic test_first_windows;
    // sorting picks the middle value out of mixed extremes
    send_window({16'd65535, 16'd0, 16'd3, 16'd0, 16'd1}, 32'd5, 10'd1023);
    // change equal to the delta is no report; elapsed one short of the period
    send_window({5{16'd101}}, 32'd900004, 10'd1000);
    // elapsed exactly the period, critical battery
    send_window({16'd65535, 16'd65534, 16'd65535, 16'd0, 16'd65535}, 32'd900005, 10'd49);
    // time at its top value, charge on the critical threshold gives low sleep
    send_window({5{16'd65435}}, 32'hFFFF_FFFF, 10'd50);
    // elapsed time across the wrap, charge on the low threshold
    send_window({5{16'd0}}, 32'd900004, 10'd200);
  endtask

  task automatic test_register_extremes;
    logic [6:0][msdr_pkg::DATA_W-1:0] values;
    int                               w;
    drain;
    values[msdr_pkg::REG_DELTA]    = 32'd0;
    values[msdr_pkg::REG_PERIOD]   = 32'd0;
    values[msdr_pkg::REG_LOW_LVL]  = 32'd1023;
    values[msdr_pkg::REG_CRIT_LVL] = 32'd0;
    values[msdr_pkg::REG_NORM_S]   = 32'd131071;
    values[msdr_pkg::REG_LOW_S]    = 32'd0;
    values[msdr_pkg::REG_CRIT_S]   = 32'hFFFF_FFFF;
    write_config(values);
    for (w = 0; w < 4; w++) random_window;
    drain;
    values[msdr_pkg::REG_DELTA]    = 32'hFFFF_FFFF;
    values[msdr_pkg::REG_PERIOD]   = 32'hFFFF_FFFF;
    values[msdr_pkg::REG_LOW_LVL]  = 32'd0;
    values[msdr_pkg::REG_CRIT_LVL] = 32'd1023;
    values[msdr_pkg::REG_NORM_S]   = 32'd0;
    values[msdr_pkg::REG_LOW_S]    = 32'd131071;
    values[msdr_pkg::REG_CRIT_S]   = 32'd65536;
    write_config(values);
    for (w = 0; w < 4; w++) random_window;
  endtask

  task automatic test_random_traffic;
    logic [6:0][msdr_pkg::DATA_W-1:0] values;
    int                               ph;
    int                               w;
    for (ph = 0; ph < 8; ph++) begin
      drain;
      case ($urandom_range(0, 5))
        0: values[msdr_pkg::REG_DELTA] = 32'd0;
        1: values[msdr_pkg::REG_DELTA] = $urandom;
        default: values[msdr_pkg::REG_DELTA] = $urandom_range(0, 1500);
      endcase
      case ($urandom_range(0, 5))
        0: values[msdr_pkg::REG_PERIOD] = 32'd0;
        1: values[msdr_pkg::REG_PERIOD] = $urandom;
        default: values[msdr_pkg::REG_PERIOD] = $urandom_range(1, 60000);
      endcase
      values[msdr_pkg::REG_LOW_LVL]  = $urandom;
      values[msdr_pkg::REG_CRIT_LVL] = $urandom;
      values[msdr_pkg::REG_NORM_S]   = $urandom;
      values[msdr_pkg::REG_LOW_S]    = $urandom;
      values[msdr_pkg::REG_CRIT_S]   = $urandom;
      write_config(values);
      max_gap = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
      burst_left = 0;
      clock_ms = $urandom;
      for (w = 0; w < 33; w++) random_window;
    end
  endtask

  initial begin
    cfg.report_delta = 16'd100;
    cfg.report_period_ms = 32'd900000;
    cfg.low_charge_level = 10'd200;
    cfg.critical_charge_level = 10'd50;
    cfg.normal_sleep_s = 17'd900;
    cfg.low_sleep_s = 17'd3600;
    cfg.critical_sleep_s = 17'd86400;
    fill_count = 0;
    reported_level = int'(msdr_pkg::LEVEL_RESET);
    report_time = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    max_gap = 6;
    level_hint = 1000;
    clock_ms = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_first_windows;
    test_register_extremes;
    test_random_traffic;
    drain;
    if (mismatch_count == 0)
      $display("median_send_on_delta_reporter_unit verification clean");
    else
      $display("median_send_on_delta_reporter_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/msdr_pkg.sv
rtl/msdr_cell.sv
rtl/msdr_report.sv
rtl/median_send_on_delta_reporter_unit.sv
bench/median_send_on_delta_reporter_unit_test.sv
